// ----- src/lkvc_pkg.sv -----
// Shared types and constants of the LRU key-value cache.
`default_nettype none
package lkvc_pkg;

  // Field widths fixed by the item format
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CapReset = 5'd16;

  // Read value returned by a get that misses
  localparam logic [VAL_W-1:0] ReadMiss = {VAL_W{1'b1}};

  // Operation carried in tuser
  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_SET = 1'b1
  } kind_e;

  // Lookup outcome from the tag array
  typedef struct packed {
    logic hit;
    logic evict;
  } lkvc_lookup_t;

endpackage
`default_nettype wire

// ----- src/lkvc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold data when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- src/lkvc_tag_array.sv -----
// Key, valid and age-rank registers with parallel lookup and LRU update.
`default_nettype none
module lkvc_tag_array
  import lkvc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16,
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CAP_W-1:0] cap_i,
  input  wire logic             upd_i,
  input  wire kind_e            kind_i,
  input  wire logic [KEY_W-1:0] key_i,
  output lkvc_lookup_t          look_o,
  output logic      [IDX_W-1:0] slot_o
);

  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  logic [KEY_W-1:0]       key_q   [MAX_ENTRIES];
  logic [RANK_W-1:0]      rank_q  [MAX_ENTRIES];
  logic [RANK_W-1:0]      rank_d  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]       count_q, count_d;

  logic [MAX_ENTRIES-1:0] match;
  logic [IDX_W-1:0]       hit_idx, free_idx, old_idx, slot;
  logic [RANK_W-1:0]      hit_rank, last_rank;
  logic [CMP_W-1:0]       cap_ext, eff_cap;
  logic                   hit, room, evict, insert;

  // Clamp capacity to one..MAX_ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cap_i);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign room      = CMP_W'(count_q) < eff_cap;
  assign last_rank = RANK_W'(count_q - CNT_W'(1));

  // Compare all keys; valid keys are unique, so OR the matching index
  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    old_idx  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == key_i);
      if (match[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank_q[i];
      end
      // Valid ranks form a permutation, so the oldest holds count-1
      if (valid_q[i] && (rank_q[i] == last_rank)) begin
        old_idx = old_idx | IDX_W'(i);
      end
    end
  end

  // Lowest free entry
  always_comb begin
    free_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit    = |match;
  assign insert = !hit && (kind_i == KIND_SET);
  assign evict  = insert && !room;

  always_comb begin
    priority if (hit) begin
      slot = hit_idx;
    end else if (evict) begin
      slot = old_idx;
    end else begin
      slot = free_idx;
    end
  end

  assign look_o = '{hit: hit, evict: evict};
  assign slot_o = slot;

  // Age ranks, valid bits and fill count for the next word
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (upd_i && hit) begin
      // Promote: entries younger than the hit age by one
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
      rank_d[slot] = '0;
    end else if (upd_i && insert) begin
      // Insert: every entry ages, the new one is the youngest
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
      rank_d[slot]  = '0;
      valid_d[slot] = 1'b1;
      if (!evict) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Store the key of a new entry
  always_ff @(posedge clk_i) begin
    if (upd_i && insert) begin
      key_q[slot] <= key_i;
    end
  end

endmodule
`default_nettype wire

// ----- src/lru_key_value_cache_top.sv -----
// Top level of the LRU key-value cache.
//
// Channels: the slave stream carries one request word per handshake:
// tuser[0] is the kind (0 get, 1 set), tdata holds key and value. The master
// stream returns one result word per request, in order: hit, read value
// (stored value on a get hit, all ones on a get miss, zero for a set) and
// the evicted flag.
// Configuration: cfg_we_i writes cfg_wdata_i to the capacity register at
// once; write it only while no request is in flight.
// Pipeline: a request is taken into the input register, where all keys are
// compared in parallel and the tag state is updated as the request advances,
// then into the output register, which is loaded together with the registered
// read of the value RAM; the result word leaves from the output register.
// Throughput: one word per cycle while the receiver holds tready high.
// Reset: all entries become free, the fill count clears and the capacity
// returns to 16; no result is pending.
// Stall: while the receiver holds tready low the result word holds, the
// input register keeps one more request, and tready on the slave side drops
// only once both registers are full.
`default_nettype none
module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] key, [63:32] value
  input  wire logic [63:0]      s_axis_tdata,
  // [0] kind
  input  wire logic [0:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // [0] hit, [32:1] read_value, [33] evicted, [39:34] zero
  output logic      [39:0]      m_axis_tdata
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [CAP_W-1:0] cap_q;
  logic             a_valid_q;
  kind_e            a_kind_q;
  logic [KEY_W-1:0] a_key_q;
  logic [VAL_W-1:0] a_value_q;
  logic             b_valid_q;
  kind_e            b_kind_q;
  logic             b_hit_q, b_evict_q;
  logic             a_adv, s_acc;
  lkvc_lookup_t     look;
  logic [IDX_W-1:0] slot;
  logic [VAL_W-1:0] rdata, read_value;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Handshake: advance when the output register is free or drains
  assign a_adv         = a_valid_q && (!b_valid_q || m_axis_tready);
  assign s_axis_tready = !a_valid_q || a_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_kind_q  <= kind_e'(s_axis_tuser[0]);
      a_key_q   <= s_axis_tdata[31:0];
      a_value_q <= s_axis_tdata[63:32];
    end
  end

  // Lookup and LRU state
  lkvc_tag_array #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_tags (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cap_i (cap_q),
    .upd_i (a_adv),
    .kind_i(a_kind_q),
    .key_i (a_key_q),
    .look_o(look),
    .slot_o(slot)
  );

  // Value store: a set writes its slot, a get hit reads it
  lkvc_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_ENTRIES)
  ) u_values (
    .clk_i  (clk_i),
    .we_i   (a_adv && (a_kind_q == KIND_SET)),
    .waddr_i(slot),
    .wdata_i(a_value_q),
    .re_i   (a_adv && (a_kind_q == KIND_GET) && look.hit),
    .raddr_i(slot),
    .rdata_o(rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (!b_valid_q || m_axis_tready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_kind_q  <= a_kind_q;
      b_hit_q   <= look.hit;
      b_evict_q <= look.evict;
    end
  end

  // Form the read value from the registered RAM data
  always_comb begin
    unique case (b_kind_q)
      KIND_GET: read_value = b_hit_q ? rdata : ReadMiss;
      KIND_SET: read_value = '0;
      default:  read_value = '0;
    endcase
  end

  assign m_axis_tvalid = b_valid_q;
  assign m_axis_tdata  = {6'b0, b_evict_q, read_value, b_hit_q};

endmodule
`default_nettype wire

// ----- src/lkvc_checker.sv -----
// Port-level checker for the LRU key-value cache, bound to the top level.
`default_nettype none
module lkvc_port_check (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // An eviction is never reported together with a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[33] && m_axis_tdata[0]))
    else $error("evicted and hit both set");

  // An eviction, which comes from a set, reports zero as read value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[32:1] == 32'd0)
    else $error("eviction with nonzero read value");

  // A miss returns all ones (get) or zero (set)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |->
      (m_axis_tdata[32:1] == 32'hFFFF_FFFF) || (m_axis_tdata[32:1] == 32'd0))
    else $error("miss with unexpected read value");

  // No result word during reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind lru_key_value_cache_top lkvc_port_check u_lkvc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
